@@ hdl/tce_pkg.sv @@
// Package for the transposed convolution tap enumerator.
// Holds widths, register indexes, the sequencer state type and the divider status struct.
// No dependencies.
package tce_pkg;

  localparam int POS_W  = 16;         // input and output positions
  localparam int KS_W   = 5;          // kernel_size register
  localparam int ST_W   = 8;          // stride and dilation
  localparam int PAD_W  = 12;         // left padding
  localparam int KIDX_W = 4;          // kernel index on the result port
  localparam int P_W    = POS_W + 1;  // padded position
  localparam int Q_W    = P_W + 1;    // signed running quotient
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;
  localparam int TAP_LIMIT = 16;      // most taps reported for one position
  localparam int CNT_W  = 5;

  localparam logic [CFG_AW-1:0] CFG_INPUT_LENGTH = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_KERNEL_SIZE  = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_STRIDE       = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_DILATION     = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_PAD_LEFT     = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_DL,
    ST_DIV_P,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic             done;
    logic [P_W-1:0]   quot;
    logic [ST_W-1:0]  rem;
  } div_stat_t;

endpackage

@@ hdl/tce_divider.sv @@
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
// Divides a padded-position-wide dividend by an 8-bit nonzero divisor.
// Depends on tce_pkg.
module tce_divider
  import tce_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [P_W-1:0]   dividend,
  input  logic [ST_W-1:0]  divisor,
  output div_stat_t        stat
);

  localparam int STEP_W = $clog2(P_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [P_W-1:0]    dvd_r;
  logic [ST_W-1:0]   rem_r;
  logic [ST_W-1:0]   dsr_r;
  logic [ST_W:0]     rem_sh;
  logic [ST_W:0]     rem_sub;
  logic              fits;

  // Bring down the next dividend bit and try the subtraction.
  assign rem_sh  = {rem_r, dvd_r[P_W-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_r};
  assign fits    = (rem_sh >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= STEP_W'(step_r + 1'b1);
        if (step_r == STEP_W'(P_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[P_W-2:0], fits};
      rem_r <= fits ? rem_sub[ST_W-1:0] : rem_sh[ST_W-1:0];
    end
  end

  assign stat.done = done_r;
  assign stat.quot = dvd_r;
  assign stat.rem  = rem_r;

endmodule

@@ hdl/conv_transpose1d_tap_enumerator_unit.sv @@
// Top level of the transposed 1D convolution tap enumerator.
// Holds the configuration registers, the sequencer and the scan datapath.
// Depends on tce_pkg and tce_divider.
//
// Usage: write the configuration through cfg_we/cfg_addr/cfg_wdata while the block
// is idle. Registers are input_length (0), kernel_size (1), stride (2), dilation (3)
// and pad_left (4); other indexes are ignored. An output position is transferred in
// when start is high and busy is low. For that position the block lists every
// (input index, kernel offset) pair that feeds it, in ascending kernel offset order.
// Each result appears for exactly one cycle with out_valid high; the receiver
// cannot stall, so every result must be taken in that cycle. The final result of a
// position has out_last set. When no tap qualifies, one result with out_tap_valid
// low and out_last high is given.
//
// Operation: the shared divider first splits dilation by stride, then the padded
// position by stride. The scan then examines one kernel offset per cycle, at most
// MAX_KERNEL of them, by stepping the quotient and remainder down by the dilation
// split, so no further division is needed. A new position is only taken once the
// last one is done; results after the first leave at most one per cycle, and busy
// drops in the cycle the last result is shown.
// Reset restores input_length=1, kernel_size=1, stride=1, dilation=1, pad_left=0
// and returns the sequencer to idle.
module conv_transpose1d_tap_enumerator_unit
  import tce_pkg::*;
#(
  parameter int MAX_KERNEL = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration write port
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [CFG_DW-1:0]   cfg_wdata,
  // command channel
  input  logic                start,
  output logic                busy,
  input  logic [POS_W-1:0]    in_out_pos,
  // result channel
  output logic                out_valid,
  output logic [POS_W-1:0]    out_in_pos,
  output logic [KIDX_W-1:0]   out_kernel_idx,
  output logic                out_tap_valid,
  output logic                out_last
);

  localparam int KW = $clog2(MAX_KERNEL + 1);

  // Configuration registers.
  logic [POS_W-1:0] input_length_r;
  logic [KS_W-1:0]  kernel_size_r;
  logic [ST_W-1:0]  stride_r;
  logic [ST_W-1:0]  dilation_r;
  logic [PAD_W-1:0] pad_left_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_length_r <= POS_W'(1);
      kernel_size_r  <= KS_W'(1);
      stride_r       <= ST_W'(1);
      dilation_r     <= ST_W'(1);
      pad_left_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_INPUT_LENGTH: input_length_r <= cfg_wdata;
        CFG_KERNEL_SIZE:  kernel_size_r  <= cfg_wdata[KS_W-1:0];
        CFG_STRIDE:       stride_r       <= cfg_wdata[ST_W-1:0];
        CFG_DILATION:     dilation_r     <= cfg_wdata[ST_W-1:0];
        CFG_PAD_LEFT:     pad_left_r     <= cfg_wdata[PAD_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero stride or dilation behaves as one; the kernel size saturates at MAX_KERNEL.
  logic [ST_W-1:0] st_eff;
  logic [ST_W-1:0] dl_eff;
  logic [KW-1:0]   ks_sat;

  assign st_eff = (stride_r == '0) ? ST_W'(1) : stride_r;
  assign dl_eff = (dilation_r == '0) ? ST_W'(1) : dilation_r;
  assign ks_sat = (int'(kernel_size_r) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(kernel_size_r);

  // Sequencer.
  state_t state_r, state_nxt;

  // Scan datapath registers.
  logic [P_W-1:0]    p_r;
  logic [ST_W-1:0]   qd_r;      // dilation / stride
  logic [ST_W-1:0]   rd_r;      // dilation % stride
  logic [Q_W-1:0]    q_r;       // (p - k*dilation) / stride, signed
  logic [ST_W-1:0]   r_r;       // (p - k*dilation) % stride
  logic [KW-1:0]     k_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              pend_valid_r;
  logic [POS_W-1:0]  pend_pos_r;
  logic [KIDX_W-1:0] pend_k_r;

  logic              out_valid_r;
  logic [POS_W-1:0]  out_in_pos_r;
  logic [KIDX_W-1:0] out_kernel_idx_r;
  logic              out_tap_valid_r;
  logic              out_last_r;

  // Shared divider.
  logic            div_start;
  logic [P_W-1:0]  div_dividend;
  div_stat_t       div_stat;

  tce_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (st_eff),
    .stat     (div_stat)
  );

  logic accept;
  assign accept = start && (state_r == ST_IDLE);

  // Scan step decisions.
  logic           scan_stop;
  logic           scan_hit;
  logic [ST_W:0]  r_diff;
  logic           borrow;
  logic [Q_W-1:0] q_step;
  logic [ST_W-1:0] r_step;

  assign scan_stop = (k_r >= ks_sat) || q_r[Q_W-1] || (cnt_r == CNT_W'(TAP_LIMIT));
  assign scan_hit  = !scan_stop && (r_r == '0) &&
                     (q_r[P_W-1:0] < {1'b0, input_length_r});

  // Move from offset k to k+1: subtract the split dilation, borrowing from the quotient.
  assign r_diff = {1'b0, r_r} - {1'b0, rd_r};
  assign borrow = r_diff[ST_W];
  assign q_step = q_r - {{(Q_W-ST_W){1'b0}}, qd_r} - {{(Q_W-1){1'b0}}, borrow};
  assign r_step = borrow ? ST_W'(r_diff[ST_W-1:0] + st_eff) : r_diff[ST_W-1:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (start)         state_nxt = ST_DIV_DL;
      ST_DIV_DL: if (div_stat.done) state_nxt = ST_DIV_P;
      ST_DIV_P:  if (div_stat.done) state_nxt = ST_SCAN;
      ST_SCAN:   if (scan_stop)     state_nxt = ST_IDLE;
      default:                      state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = p_r;
    busy         = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy         = 1'b0;
        div_start    = start;
        div_dividend = {{(P_W-ST_W){1'b0}}, dl_eff};
      end
      ST_DIV_DL: begin
        div_start    = div_stat.done;
        div_dividend = p_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      p_r <= P_W'(in_out_pos) + P_W'(pad_left_r);
    end
    if (state_r == ST_DIV_DL && div_stat.done) begin
      qd_r <= div_stat.quot[ST_W-1:0];
      rd_r <= div_stat.rem;
    end
    if (state_r == ST_DIV_P && div_stat.done) begin
      q_r <= {1'b0, div_stat.quot};
      r_r <= div_stat.rem;
      k_r <= '0;
    end else if (state_r == ST_SCAN) begin
      q_r <= q_step;
      r_r <= r_step;
      k_r <= KW'(k_r + 1'b1);
    end
    if (scan_hit && state_r == ST_SCAN) begin
      pend_pos_r <= q_r[POS_W-1:0];
      pend_k_r   <= KIDX_W'(k_r);
    end
  end

  // Control registers of the scan: tap count and the pending tap flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
    end else if (state_r == ST_DIV_P && div_stat.done) begin
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
    end else if (state_r == ST_SCAN && scan_hit) begin
      cnt_r        <= CNT_W'(cnt_r + 1'b1);
      pend_valid_r <= 1'b1;
    end
  end

  // A tap is held back until the next tap or the end of the scan, so that the final one can carry the last flag.
  logic emit;
  assign emit = (state_r == ST_SCAN) && (scan_stop || (scan_hit && pend_valid_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_in_pos_r     <= pend_valid_r ? pend_pos_r : '0;
      out_kernel_idx_r <= pend_valid_r ? pend_k_r : '0;
      out_tap_valid_r  <= pend_valid_r;
      out_last_r       <= scan_stop;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_in_pos     = out_in_pos_r;
  assign out_kernel_idx = out_kernel_idx_r;
  assign out_tap_valid  = out_tap_valid_r;
  assign out_last       = out_last_r;

endmodule

@@ hdl/tce_checker.sv @@
// Port-level checks for the transposed convolution tap enumerator, bound to the top level.
// Depends on tce_pkg and conv_transpose1d_tap_enumerator_unit.
module tce_checker
  import tce_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [POS_W-1:0]  out_in_pos,
  input logic [KIDX_W-1:0] out_kernel_idx,
  input logic              out_tap_valid,
  input logic              out_last
);

  // A transfer in keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after a transfer in");

  // More results of the same position follow a result that is not last.
  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("block idle while a position still has results");

  // The no-tap result stands alone and carries zero indexes.
  a_notap_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_tap_valid) |-> (out_last && out_in_pos == '0 && out_kernel_idx == '0))
    else $error("no-tap result malformed");

  // Nothing is shown in the cycle right after the last result of a position.
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("result shown right after the last result");

endmodule

bind conv_transpose1d_tap_enumerator_unit tce_checker u_tce_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_in_pos     (out_in_pos),
  .out_kernel_idx (out_kernel_idx),
  .out_tap_valid  (out_tap_valid),
  .out_last       (out_last)
);

@@ dv/conv_transpose1d_tap_enumerator_unit_test.sv @@
// Self-checking testbench for the transposed 1D convolution tap enumerator.
// A scoreboard class predicts the taps of every accepted output position; tasks drive it.
// Depends on tce_pkg and conv_transpose1d_tap_enumerator_unit.
module conv_transpose1d_tap_enumerator_unit_test;
  import tce_pkg::*;

  localparam int MAX_KERNEL    = 16;
  localparam int RANDOM_ITEMS  = 210;
  localparam int QUIET_TAIL    = 30;          // last random items are sent with no idling
  localparam int SETTLE_CYCLES = 8;           // margin after the last result of a phase
  localparam int REPORT_LIMIT  = 10;
  localparam int TIMEOUT_TICKS = 4_000_000;   // far above a clean run

  // Indexes that map to no register; writes to them must change nothing.
  localparam logic [CFG_AW-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_SPARE_HI = 3'd7;

  // One result as it appears on the out_ ports.
  typedef struct packed {
    logic [POS_W-1:0]  in_pos;
    logic [KIDX_W-1:0] kernel_idx;
    logic              tap_valid;
    logic              last;
  } tap_t;

  // Scoreboard: keeps its own copy of the registers, turns every accepted output
  // position into the list of taps it should produce, and checks results in order.
  class tap_scoreboard;
    logic [POS_W-1:0] input_length;
    logic [KS_W-1:0]  kernel_size;
    logic [ST_W-1:0]  stride;
    logic [ST_W-1:0]  dilation;
    logic [PAD_W-1:0] pad_left;
    tap_t             expected_taps[$];
    int               failures;

    function new();
      input_length = 1;
      kernel_size  = 1;
      stride       = 1;
      dilation     = 1;
      pad_left     = 0;
      failures     = 0;
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= REPORT_LIMIT)
        $display("%s", msg);
    endfunction

    // Only the low bits of each register are kept; unmapped indexes are ignored.
    function void write_register(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
      case (addr)
        CFG_INPUT_LENGTH: input_length = data[POS_W-1:0];
        CFG_KERNEL_SIZE:  kernel_size  = data[KS_W-1:0];
        CFG_STRIDE:       stride       = data[ST_W-1:0];
        CFG_DILATION:     dilation     = data[ST_W-1:0];
        CFG_PAD_LEFT:     pad_left     = data[PAD_W-1:0];
        default: ;
      endcase
    endfunction

    // Walks the kernel offsets of one output position in ascending order.
    // A tap is found wherever the distance from the padded position to the
    // offset is a multiple of the stride and the quotient is a valid input index.
    // The most recent tap is held back so that its last flag can be set once
    // the walk is over.
    function void note_position(logic [POS_W-1:0] out_pos);
      logic [P_W-1:0] padded;
      int unsigned    eff_stride;
      int unsigned    eff_dilation;
      int unsigned    scan_len;
      int unsigned    offset_span;
      int unsigned    distance;
      int unsigned    quotient;
      int             found;
      bit             have_pending;
      tap_t           pending;
      padded       = P_W'(out_pos) + P_W'(pad_left);
      eff_stride   = (stride == 0) ? 1 : stride;
      eff_dilation = (dilation == 0) ? 1 : dilation;
      scan_len     = (kernel_size > MAX_KERNEL) ? MAX_KERNEL : kernel_size;
      found        = 0;
      have_pending = 1'b0;
      pending      = '0;
      for (int unsigned k = 0; k < scan_len; k++) begin
        offset_span = k * eff_dilation;
        if (offset_span > padded)
          break;
        if (found >= TAP_LIMIT)
          break;
        distance = padded - offset_span;
        if (distance % eff_stride != 0)
          continue;
        quotient = distance / eff_stride;
        if (quotient >= input_length)
          continue;
        if (have_pending)
          expected_taps.push_back(pending);
        pending.in_pos     = POS_W'(quotient);
        pending.kernel_idx = KIDX_W'(k);
        pending.tap_valid  = 1'b1;
        pending.last       = 1'b0;
        have_pending       = 1'b1;
        found++;
      end
      // With no tap at all a single empty result closes the position.
      if (!have_pending)
        pending = '0;
      pending.last = 1'b1;
      expected_taps.push_back(pending);
    endfunction

    function void check_tap(tap_t got);
      tap_t want;
      if (expected_taps.size() == 0) begin
        note_failure($sformatf("unexpected result: in_pos=%0d kernel_idx=%0d tap_valid=%0b last=%0b",
                               got.in_pos, got.kernel_idx, got.tap_valid, got.last));
        return;
      end
      want = expected_taps.pop_front();
      if (got.in_pos !== want.in_pos || got.kernel_idx !== want.kernel_idx ||
          got.tap_valid !== want.tap_valid || got.last !== want.last)
        note_failure($sformatf({"mismatch: expected in_pos=%0d kernel_idx=%0d tap_valid=%0b",
                                " last=%0b, got in_pos=%0d kernel_idx=%0d tap_valid=%0b last=%0b"},
                               want.in_pos, want.kernel_idx, want.tap_valid, want.last,
                               got.in_pos, got.kernel_idx, got.tap_valid, got.last));
    endfunction
  endclass

  // Every input of the block starts at a known value.
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr = '0;
  logic [CFG_DW-1:0]   cfg_wdata = '0;
  logic                start = 1'b0;
  logic                busy;
  logic [POS_W-1:0]    in_out_pos = '0;
  logic                out_valid;
  logic [POS_W-1:0]    out_in_pos;
  logic [KIDX_W-1:0]   out_kernel_idx;
  logic                out_tap_valid;
  logic                out_last;

  tap_scoreboard sb;
  bit            idle_enabled = 1'b1;

  conv_transpose1d_tap_enumerator_unit #(
    .MAX_KERNEL(MAX_KERNEL)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .start          (start),
    .busy           (busy),
    .in_out_pos     (in_out_pos),
    .out_valid      (out_valid),
    .out_in_pos     (out_in_pos),
    .out_kernel_idx (out_kernel_idx),
    .out_tap_valid  (out_tap_valid),
    .out_last       (out_last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // The run is cut off after a fixed time in case the block hangs.
  initial begin
    #(TIMEOUT_TICKS);
    $display("conv_transpose1d_tap_enumerator_unit_test: done, errors");
    $finish;
  end

  // The receiver cannot stall, so every strobed result is taken at the edge that
  // ends its cycle. Reading the ports at the edge sees the values from before it.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_tap({out_in_pos, out_kernel_idx, out_tap_valid, out_last});
  end

  // A register write takes effect at the next edge; the mirror is updated then.
  // The caller lowers cfg_we once its writes are done.
  task automatic write_register(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_register(addr, data);
  endtask

  task automatic apply_settings(input logic [CFG_DW-1:0] len, input logic [CFG_DW-1:0] ks,
                                input logic [CFG_DW-1:0] st, input logic [CFG_DW-1:0] dl,
                                input logic [CFG_DW-1:0] pad);
    write_register(CFG_INPUT_LENGTH, len);
    write_register(CFG_KERNEL_SIZE, ks);
    write_register(CFG_STRIDE, st);
    write_register(CFG_DILATION, dl);
    write_register(CFG_PAD_LEFT, pad);
    cfg_we <= 1'b0;
  endtask

  // Offers one output position and returns at the edge that transfers it. Between
  // back-to-back items start simply stays high. An idle burst either starts right
  // away, hidden behind busy, or only after busy has dropped, so that the gap
  // lands while the block is waiting for work.
  task automatic send_position(input logic [POS_W-1:0] pos);
    int unsigned gap;
    if (idle_enabled && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      if ($urandom_range(0, 1) == 0) begin
        do @(posedge clk); while (busy !== 1'b0);
      end
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_out_pos <= pos;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_position(pos);
  endtask

  // Lets the block finish: every expected result in and busy low, then a margin.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (sb.expected_taps.size() != 0 || busy !== 1'b0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly picks positions that land on a real tap under the current settings:
  // a quotient inside the input range, stepped by the stride, plus some kernel
  // offset, minus the padding. The rest are full-range or very small positions.
  function automatic logic [POS_W-1:0] pick_position();
    int unsigned eff_stride;
    int unsigned eff_dilation;
    int unsigned target;
    eff_stride   = (sb.stride == 0) ? 1 : sb.stride;
    eff_dilation = (sb.dilation == 0) ? 1 : sb.dilation;
    case ($urandom_range(0, 9))
      0, 1: return POS_W'($urandom);
      8, 9: return POS_W'($urandom_range(0, 63));
      default: begin
        target = (sb.input_length == 0) ? 0 : $urandom_range(0, sb.input_length - 1);
        target = target * eff_stride + $urandom_range(0, MAX_KERNEL - 1) * eff_dilation;
        if (target >= sb.pad_left)
          return POS_W'(target - sb.pad_left);
        return POS_W'($urandom_range(0, 63));
      end
    endcase
  endfunction

  // Sometimes sets the unused upper bits of a register write, which must be dropped.
  function automatic logic [CFG_DW-1:0] with_junk(input int unsigned value, input int width);
    logic [CFG_DW-1:0] junk;
    junk = CFG_DW'($urandom);
    if ($urandom_range(0, 3) != 0)
      junk = '0;
    return CFG_DW'(value) | ((junk >> width) << width);
  endfunction

  initial begin
    int unsigned len;
    int unsigned ks;
    int unsigned st;
    int unsigned dl;
    int unsigned pad;
    int unsigned burst;
    int unsigned random_sent;
    sb = new();
    random_sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Settings straight out of reset: one input, one tap, unit stride.
    // Position zero hits input zero; the top position hits nothing.
    send_position(16'd0);
    send_position(16'hFFFF);
    drain_results();

    // Widest scan: sixteen taps, a quotient just at the input length, and a
    // scan that ends early because the offset passes the padded position.
    apply_settings(16'hFFFF, 16, 1, 1, 0);
    send_position(16'd15);
    send_position(16'hFFFF);
    send_position(16'd3);
    drain_results();

    // Kernel size above the maximum saturates, zero stride and dilation act as
    // one, and the padded position reaches beyond the position width. Writes to
    // unmapped indexes follow after a pause with cfg_we low and must leave the registers alone.
    apply_settings(16'hFFFF, 31, 0, 0, 4095);
    @(posedge clk);
    write_register(CFG_SPARE_LO, 16'hFFFF);
    write_register(CFG_SPARE_HI, 16'h0000);
    cfg_we <= 1'b0;
    send_position(16'hFFFF);
    send_position(16'd0);
    drain_results();

    // Zero input length: no quotient can qualify.
    apply_settings(0, 16, 1, 1, 0);
    send_position(16'd20);
    drain_results();

    // Zero kernel size: nothing is scanned at all.
    apply_settings(16'hFFFF, 0, 1, 1, 0);
    send_position(16'd5);
    drain_results();

    // Largest stride and dilation with a single input position.
    apply_settings(1, 16, 255, 255, 0);
    send_position(16'd0);
    send_position(16'd255);
    send_position(16'd254);
    drain_results();

    // Uneven stride and dilation, so only some offsets line up.
    apply_settings(100, 8, 3, 2, 7);
    send_position(16'd0);
    send_position(16'd13);
    send_position(16'hFFFF);
    drain_results();

    // Largest padding with stride two.
    apply_settings(4096, 16, 2, 1, 4095);
    send_position(16'd0);
    send_position(16'hFFFF);
    send_position(16'd31);
    drain_results();

    // Random phases: fresh settings, then a burst of positions aimed mostly at
    // real taps. Idling stops for the last stretch so items go back to back.
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:          len = 0;
        1, 2, 3, 4: len = $urandom_range(1, 64);
        5, 6, 7:    len = $urandom_range(1, 65535);
        8:          len = 65535;
        default:    len = 1;
      endcase
      case ($urandom_range(0, 9))
        0:       ks = 0;
        1:       ks = $urandom_range(MAX_KERNEL + 1, 31);
        2:       ks = MAX_KERNEL;
        default: ks = $urandom_range(1, MAX_KERNEL);
      endcase
      case ($urandom_range(0, 9))
        0:       st = 0;
        1:       st = 255;
        2:       st = $urandom_range(1, 255);
        default: st = $urandom_range(1, 4);
      endcase
      case ($urandom_range(0, 9))
        0:       dl = 0;
        1:       dl = 255;
        2:       dl = $urandom_range(1, 255);
        default: dl = $urandom_range(1, 4);
      endcase
      case ($urandom_range(0, 9))
        0:       pad = 0;
        1:       pad = 4095;
        2, 3:    pad = $urandom_range(0, 4095);
        default: pad = $urandom_range(0, 31);
      endcase
      apply_settings(CFG_DW'(len), with_junk(ks, KS_W), with_junk(st, ST_W),
                     with_junk(dl, ST_W), with_junk(pad, PAD_W));
      burst = $urandom_range(6, 20);
      for (int i = 0; i < burst && random_sent < RANDOM_ITEMS; i++) begin
        idle_enabled = (random_sent < RANDOM_ITEMS - QUIET_TAIL);
        send_position(pick_position());
        random_sent++;
      end
      drain_results();
    end

    if (sb.expected_taps.size() != 0)
      sb.note_failure($sformatf("%0d expected results never arrived", sb.expected_taps.size()));
    if (sb.failures == 0)
      $display("conv_transpose1d_tap_enumerator_unit_test: done, clean");
    else
      $display("conv_transpose1d_tap_enumerator_unit_test: done, errors");
    $finish;
  end

endmodule

@@ conv_transpose1d_tap_enumerator_unit.f @@
hdl/tce_pkg.sv
hdl/tce_divider.sv
hdl/conv_transpose1d_tap_enumerator_unit.sv
hdl/tce_checker.sv
dv/conv_transpose1d_tap_enumerator_unit_test.sv
